@@ rtl/core/text_terminal_glyph_generator_macros.svh @@
// Assertion macros for the text terminal glyph generator.
`ifndef TEXT_TERMINAL_GLYPH_GENERATOR_MACROS_SVH
`define TEXT_TERMINAL_GLYPH_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold on every clock edge outside reset.
`define TTG_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Antecedent implies consequent on the following edge.
`define TTG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTG_ASSERT(name, clk, rst_n, prop, msg)
`define TTG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/ttg_pkg.sv @@
// Shared types and character codes for the text terminal glyph generator.
package ttg_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_LOAD  = 2'd1,
        OP_FETCH = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT_RD,
        S_PUT_CHK,
        S_BS_WR,
        S_SCROLL,
        S_MARK,
        S_LOAD,
        S_F_DIV,
        S_F_REM,
        S_F_CRD,
        S_F_CHK,
        S_F_FNT,
        S_DONE
    } t_state;

    localparam logic [7:0] C_CR          = 8'd13;
    localparam logic [7:0] C_LF          = 8'd10;
    localparam logic [7:0] C_BS          = 8'd8;
    localparam logic [7:0] C_FIRST_PRINT = 8'd32;
    localparam logic [7:0] C_LAST_PRINT  = 8'd126;
    localparam logic [6:0] C_CELL_SPACE  = 7'd32;
    localparam logic [6:0] C_CELL_MARK   = 7'd95;
    localparam logic [6:0] C_CELL_FIRST  = 7'd32;
    localparam logic [6:0] C_CELL_LAST   = 7'd126;
    localparam logic [6:0] C_GLYPHS      = 7'd95;

endpackage

@@ rtl/core/ttg_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module ttg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/text_terminal_glyph_generator.sv @@
// Text terminal with character store, cursor, font store and glyph fetch.
// After reset the block sweeps the character store to spaces, one cell a cycle
// (all TEXT_COLUMNS*TEXT_ROWS cells, 2400 by default), and takes no transfer
// until that is done. Items are handled one at a time, each going through read,
// modify and write-back steps on the character and font memories: a load
// writes a font row; a fetch splits the scan line, reads the cell, then its
// font row; a put updates the cursor cell and also writes the cursor mark for
// a printable character or blanks the previous cell for a backspace away from
// cell zero; an unused opcode goes straight to the result. A put that scrolls
// blanks the old top row of the ring one cell a cycle. A finished result waits
// in the output register; the next item is taken as soon as the block is idle.
`include "text_terminal_glyph_generator_macros.svh"

module text_terminal_glyph_generator #(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 30,
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // char_code[7:0], font_glyph[14:8], font_row[18:15], font_bits[26:19],
    // scan_line[35:27], column[42:36], zero fill[47:43]
    input  logic [47:0] i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // pixel_bits[7:0], cursor_pos[19:8], scrolled[20], zero fill[23:21]
    output logic [23:0] o_m_tdata
);
    import ttg_pkg::*;

    localparam int CELLS   = TEXT_COLUMNS * TEXT_ROWS;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(TEXT_COLUMNS);
    localparam int ROW_W   = $clog2(TEXT_ROWS);
    localparam int GH_W    = $clog2(GLYPH_HEIGHT);
    localparam int FDEPTH  = 95 * GLYPH_HEIGHT;
    localparam int FA_W    = $clog2(FDEPTH);
    localparam int LINES   = TEXT_ROWS * GLYPH_HEIGHT;
    localparam int LINE_W  = 9;
    localparam int SH      = 16;
    localparam int RECIP   = (1 << SH) / GLYPH_HEIGHT;
    localparam int PROD_W  = LINE_W + SH;
    localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'(TEXT_COLUMNS * (TEXT_ROWS - 1));

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic [7:0]        r_ch;
    logic [6:0]        r_glyph;
    logic [3:0]        r_frow;
    logic [7:0]        r_fbits;
    logic [LINE_W-1:0] r_line;
    logic [6:0]        r_fcol;

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CELL_W-1:0] r_idx;
    logic [ROW_W-1:0]  r_top;
    logic [CELL_W-1:0] r_cnt;

    logic              r_mark;
    logic              r_scr;
    logic              r_zero;
    logic [7:0]        r_pix;
    logic [LINE_W-1:0] r_q;
    logic [ROW_W-1:0]  r_cell_row;
    logic [GH_W-1:0]   r_grow;

    logic              r_out_valid;
    logic [7:0]        r_out_pix;
    logic [11:0]       r_out_cur;
    logic              r_out_scr;

    // ------------------------------------------------------------- memories
    logic              c_we;
    logic [CELL_W-1:0] c_waddr;
    logic [6:0]        c_wdata;
    logic [CELL_W-1:0] c_raddr;
    logic [6:0]        c_rdata;

    logic              f_we;
    logic [FA_W-1:0]   f_waddr;
    logic [FA_W-1:0]   f_raddr;
    logic [7:0]        f_rdata;

    ttg_ram #(.WIDTH(7), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    ttg_ram #(.WIDTH(8), .DEPTH(FDEPTH)) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (r_fbits),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // ---------------------------------------------------------------- helpers
    function automatic logic [CELL_W-1:0] f_phys(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, row} + {1'b0, top};
        if (s >= (ROW_W+1)'(TEXT_ROWS)) begin
            s = s - (ROW_W+1)'(TEXT_ROWS);
        end
        return CELL_W'(s) * CELL_W'(TEXT_COLUMNS) + CELL_W'(col);
    endfunction

    logic              w_s_xfer;
    logic              w_out_free;
    logic              w_print;
    logic              w_is_cr;
    logic              w_is_lf;
    logic              w_is_bs;
    logic              w_col_last;
    logic              w_row_last;
    logic              w_mark_hit;
    logic              w_cell_print;
    logic              w_font_ok;
    logic              w_out_range;
    logic [CELL_W-1:0] w_here;
    logic [PROD_W-1:0] w_prod;
    logic [LINE_W-1:0] w_qgh;
    logic [LINE_W-1:0] w_rem;
    logic [CELL_W+11:0] w_idx_ext;

    assign w_s_xfer     = i_s_tvalid && o_s_tready;
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_print      = (r_ch >= C_FIRST_PRINT) && (r_ch <= C_LAST_PRINT);
    assign w_is_cr      = (r_ch == C_CR);
    assign w_is_lf      = (r_ch == C_LF);
    assign w_is_bs      = (r_ch == C_BS);
    assign w_col_last   = (r_col == COL_W'(TEXT_COLUMNS - 1));
    assign w_row_last   = (r_row == ROW_W'(TEXT_ROWS - 1));
    assign w_mark_hit   = (c_rdata == C_CELL_MARK);
    assign w_cell_print = (c_rdata >= C_CELL_FIRST) && (c_rdata <= C_CELL_LAST);
    assign w_font_ok    = (r_glyph < C_GLYPHS) && (32'(r_frow) < 32'(GLYPH_HEIGHT));
    assign w_out_range  = (32'(r_line) >= 32'(LINES)) || (32'(r_fcol) >= 32'(TEXT_COLUMNS));
    assign w_here       = f_phys(r_row, r_col, r_top);
    assign w_prod       = PROD_W'(r_line) * PROD_W'(RECIP);
    assign w_qgh        = LINE_W'(32'(r_q) * 32'(GLYPH_HEIGHT));
    assign w_rem        = r_line - w_qgh;
    assign w_idx_ext    = {12'd0, r_idx};

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == CELL_W'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_s_xfer) begin
                    case (i_s_tuser)
                        OP_PUT:   n_state = S_PUT_RD;
                        OP_LOAD:  n_state = S_LOAD;
                        OP_FETCH: n_state = S_F_DIV;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_PUT_RD:  n_state = S_PUT_CHK;
            S_PUT_CHK: begin
                if (w_print) begin
                    n_state = (w_col_last && w_row_last) ? S_SCROLL : S_MARK;
                end else if (w_is_bs && r_idx != '0) begin
                    n_state = S_BS_WR;
                end else if (w_is_lf && w_row_last) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BS_WR:   n_state = S_DONE;
            S_SCROLL: begin
                if (r_cnt == CELL_W'(TEXT_COLUMNS - 1)) n_state = r_mark ? S_MARK : S_DONE;
            end
            S_MARK:    n_state = S_DONE;
            S_LOAD:    n_state = S_DONE;
            S_F_DIV:   n_state = S_F_REM;
            S_F_REM:   n_state = S_F_CRD;
            S_F_CRD:   n_state = S_F_CHK;
            S_F_CHK:   n_state = S_F_FNT;
            S_F_FNT:   n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    // ------------------------------------------------------- memory controls
    always_comb begin
        c_we    = 1'b0;
        c_waddr = w_here;
        c_wdata = C_CELL_SPACE;
        c_raddr = w_here;
        f_we    = 1'b0;
        f_waddr = FA_W'(r_glyph) * FA_W'(GLYPH_HEIGHT) + FA_W'(r_frow);
        f_raddr = FA_W'(c_rdata - C_CELL_FIRST) * FA_W'(GLYPH_HEIGHT) + FA_W'(r_grow);
        unique case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_cnt;
            end
            S_PUT_CHK: begin
                if (w_print) begin
                    c_we    = 1'b1;
                    c_wdata = r_ch[6:0];
                end else if (w_is_bs && r_idx != '0) begin
                    c_we = 1'b1;
                end else begin
                    // drop the cursor mark only
                    c_we = w_mark_hit;
                end
            end
            S_BS_WR:  c_we = 1'b1;
            S_SCROLL: begin
                c_we    = 1'b1;
                c_waddr = CELL_W'(r_top) * CELL_W'(TEXT_COLUMNS) + CELL_W'(r_cnt[COL_W-1:0]);
            end
            S_MARK: begin
                c_we    = 1'b1;
                c_wdata = C_CELL_MARK;
            end
            S_LOAD:  f_we = w_font_ok;
            S_F_CRD: c_raddr = f_phys(r_cell_row, COL_W'(r_fcol), r_top);
            default: ;
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_top       <= '0;
            r_mark      <= 1'b0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_pix   <= r_pix;
                r_out_cur   <= w_idx_ext[11:0];
                r_out_scr   <= r_scr;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: r_cnt <= r_cnt + CELL_W'(1);
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_mark <= 1'b0;
                    r_scr  <= 1'b0;
                    r_pix  <= '0;
                    r_zero <= 1'b0;
                    if (w_s_xfer) begin
                        r_ch    <= i_s_tdata[7:0];
                        r_glyph <= i_s_tdata[14:8];
                        r_frow  <= i_s_tdata[18:15];
                        r_fbits <= i_s_tdata[26:19];
                        r_line  <= i_s_tdata[35:27];
                        r_fcol  <= i_s_tdata[42:36];
                    end
                end
                S_PUT_CHK: begin
                    if (w_print) begin
                        r_mark <= 1'b1;
                        if (w_col_last) begin
                            r_col <= '0;
                            if (w_row_last) begin
                                r_idx <= LAST_ROW_START;
                                r_scr <= 1'b1;
                            end else begin
                                r_row <= r_row + ROW_W'(1);
                                r_idx <= r_idx + CELL_W'(1);
                            end
                        end else begin
                            r_col <= r_col + COL_W'(1);
                            r_idx <= r_idx + CELL_W'(1);
                        end
                    end else if (w_is_cr) begin
                        r_col <= '0;
                        r_idx <= r_idx - CELL_W'(r_col);
                    end else if (w_is_lf) begin
                        r_col <= '0;
                        if (w_row_last) begin
                            r_idx <= LAST_ROW_START;
                            r_scr <= 1'b1;
                        end else begin
                            r_row <= r_row + ROW_W'(1);
                            r_idx <= r_idx - CELL_W'(r_col) + CELL_W'(TEXT_COLUMNS);
                        end
                    end else if (w_is_bs && r_idx != '0) begin
                        r_idx <= r_idx - CELL_W'(1);
                        if (r_col == '0) begin
                            r_col <= COL_W'(TEXT_COLUMNS - 1);
                            r_row <= r_row - ROW_W'(1);
                        end else begin
                            r_col <= r_col - COL_W'(1);
                        end
                    end
                end
                S_SCROLL: begin
                    r_cnt <= r_cnt + CELL_W'(1);
                    // advance the ring once the old top row is blank
                    if (r_cnt == CELL_W'(TEXT_COLUMNS - 1)) begin
                        r_top <= (r_top == ROW_W'(TEXT_ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                    end
                end
                S_F_DIV: begin
                    r_q    <= LINE_W'(w_prod >> SH);
                    r_zero <= w_out_range;
                end
                S_F_REM: begin
                    // reciprocal quotient may be one short
                    if (w_rem >= LINE_W'(GLYPH_HEIGHT)) begin
                        r_cell_row <= ROW_W'(r_q + LINE_W'(1));
                        r_grow     <= GH_W'(w_rem - LINE_W'(GLYPH_HEIGHT));
                    end else begin
                        r_cell_row <= ROW_W'(r_q);
                        r_grow     <= GH_W'(w_rem);
                    end
                end
                S_F_CHK: begin
                    if (!w_cell_print) r_zero <= 1'b1;
                end
                S_F_FNT: r_pix <= r_zero ? 8'd0 : f_rdata;
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_scr, r_out_cur, r_out_pix};

    // ------------------------------------------------------------ assertions
    `TTG_ASSERT(a_cursor_consistent, i_clk, i_rst_n,
        r_idx == CELL_W'(r_row) * CELL_W'(TEXT_COLUMNS) + CELL_W'(r_col),
        "cursor index disagrees with row and column")
    `TTG_ASSERT(a_top_in_range, i_clk, i_rst_n,
        32'(r_top) < 32'(TEXT_ROWS),
        "top row offset out of range")
    `TTG_ASSERT(a_scroll_cursor, i_clk, i_rst_n,
        !(o_m_tvalid && o_m_tdata[20])
            || o_m_tdata[19:8] == 12'(TEXT_COLUMNS * (TEXT_ROWS - 1)),
        "scrolled result without cursor at start of last row")
    `TTG_ASSERT_NEXT(a_scroll_sweep_ends, i_clk, i_rst_n,
        r_state == S_SCROLL && r_cnt == CELL_W'(TEXT_COLUMNS - 1),
        r_state == S_MARK || r_state == S_DONE,
        "row blanking sweep did not finish after one row")

endmodule
